>>> rtl/lphs_pkg.sv
`default_nettype none

package lphs_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned OCC_W    = 5;
	localparam int unsigned STATUS_W = 2;

	// Default table size.
	localparam int unsigned TABLE_SLOTS_DEF = 16;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Per-slot marks.
	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_LIVE    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

endpackage

`default_nettype wire

>>> rtl/lphs_if.sv
`default_nettype none

// Request channel: one insert or delete operation per beat.
interface lphs_req_if import lphs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [KEY_W-1:0] key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink   (input valid, input opcode, input key, output ready);
endinterface

// Response channel: one result per operation.
interface lphs_rsp_if import lphs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output slot, output occupancy, input ready);
	modport sink   (input valid, input status, input slot, input occupancy, output ready);
endinterface

`default_nettype wire

>>> rtl/linear_probe_hash_set.sv
// Hash set of TABLE_SLOTS keys with open addressing and linear probing.
// The req channel carries one operation per beat: insert (store the key in the
// first empty or deleted slot from its home slot) or delete (mark the first
// live slot holding the key as deleted). The rsp channel returns one beat per
// operation with a status, the slot used and the number of live keys.
// The home slot is the key modulo TABLE_SLOTS. For a power-of-two size this is
// a mask; otherwise a reciprocal multiplication on a shared multiplier is
// done in the S_MOD state before the probe walk starts.
// The probe walk reads one slot per cycle from the slot memories through a
// registered read port. Only one operation is in flight at a time.
// After reset every slot mark is cleared to empty by a pass over all slots,
// during which req.ready stays low.
// The response sits in an output register; a new request is accepted while it
// waits, but the next result is held back until the receiver has taken it.
// A full table on insert writes nothing and reports full.
`default_nettype none

module linear_probe_hash_set import lphs_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lphs_req_if.sink   req,
	lphs_rsp_if.source rsp
);

	localparam int unsigned LW   = $clog2(TABLE_SLOTS);
	localparam int unsigned CW   = $clog2(TABLE_SLOTS + 1);
	localparam bit          POW2 = (TABLE_SLOTS == (1 << LW));
	localparam logic [LW-1:0] LAST = LW'(TABLE_SLOTS - 1);
	localparam logic [LW-1:0] NLO  = LW'(TABLE_SLOTS);
	// Rounded-up reciprocal of the table size, scaled by 2 to the power RSH.
	localparam int unsigned RSH  = KEY_W + LW;
	localparam logic [31:0] RECIP = 32'(((64'd1 << RSH) + 64'(TABLE_SLOTS) - 64'd1)
		/ 64'(TABLE_SLOTS));

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_PROBE,
		S_WRITE
	} state_t;

	state_t               state_q;
	logic                 op_q;
	logic [KEY_W-1:0]     key_q;
	logic [LW-1:0]        addr_q;
	logic [LW-1:0]        cmp_addr_q;
	logic                 rd_vld_q;
	logic [LW-1:0]        cnt_q;
	logic                 hit_q;
	logic [LW-1:0]        hit_addr_q;
	logic [1:0]           mstep_q;
	logic [KEY_W+31:0]    acc_q;
	logic [CW-1:0]        live_q;
	logic                 out_vld_q;
	status_t              status_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [OCC_W-1:0]     occ_q;

	// Slot memories with a registered read port.
	mark_t                mark_mem [TABLE_SLOTS];
	logic [KEY_W-1:0]     key_mem  [TABLE_SLOTS];
	mark_t                mark_rd_q;
	logic [KEY_W-1:0]     key_rd_q;

	logic                 mark_we;
	logic [LW-1:0]        mark_wa;
	mark_t                mark_wd;
	logic                 key_we;
	logic [LW-1:0]        addr_nxt;
	logic                 hit;
	logic [15:0]          mul_b;
	logic [KEY_W+15:0]    prod;
	logic [LW-1:0]        q_lo;
	logic [LW-1:0]        rem_nxt;
	logic                 wr_go;
	logic [CW-1:0]        live_nxt;

	// Next probe address, wrapping at the end of the table.
	assign addr_nxt = (addr_q == LAST) ? '0 : addr_q + 1'b1;

	// Slot match for the data read in the previous cycle.
	always_comb begin
		if (op_q == OP_INSERT) begin
			hit = (mark_rd_q != MARK_LIVE);
		end else begin
			hit = (mark_rd_q == MARK_LIVE) && (key_rd_q == key_q);
		end
	end

	// Shared multiplier: the key times one half of the reciprocal per step.
	assign mul_b   = (mstep_q == 2'd0) ? RECIP[15:0] : RECIP[31:16];
	assign prod    = {16'b0, key_q} * {{KEY_W{1'b0}}, mul_b};
	// Low bits of the quotient give the remainder modulo the table size.
	assign q_lo    = acc_q[RSH +: LW];
	assign rem_nxt = key_q[LW-1:0] - q_lo * NLO;

	// The write-back waits until the previous response has been taken.
	assign wr_go = (state_q == S_WRITE) && (!out_vld_q || rsp.ready);

	// Live count after a successful operation.
	always_comb begin
		if (op_q == OP_INSERT) begin
			live_nxt = live_q + 1'b1;
		end else if (live_q != '0) begin
			live_nxt = live_q - 1'b1;
		end else begin
			live_nxt = live_q;
		end
	end

	// Memory write controls: the clearing pass or the write-back.
	always_comb begin
		mark_we = 1'b0;
		mark_wa = hit_addr_q;
		mark_wd = MARK_EMPTY;
		key_we  = 1'b0;
		if (state_q == S_CLEAR) begin
			mark_we = 1'b1;
			mark_wa = addr_q;
		end else if (wr_go && hit_q) begin
			mark_we = 1'b1;
			mark_wd = (op_q == OP_INSERT) ? MARK_LIVE : MARK_DELETED;
			key_we  = (op_q == OP_INSERT);
		end
	end

	// Slot memories.
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (key_we) begin
			key_mem[hit_addr_q] <= key_q;
		end
		mark_rd_q <= mark_mem[addr_q];
		key_rd_q  <= key_mem[addr_q];
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			op_q       <= OP_INSERT;
			key_q      <= '0;
			addr_q     <= '0;
			cmp_addr_q <= '0;
			rd_vld_q   <= 1'b0;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			hit_addr_q <= '0;
			mstep_q    <= '0;
			acc_q      <= '0;
			live_q     <= '0;
			out_vld_q  <= 1'b0;
			status_q   <= ST_DONE;
			slot_q     <= '0;
			occ_q      <= '0;
		end else begin
			if (out_vld_q && rsp.ready && !wr_go) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_nxt;
					if (addr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.opcode;
						key_q    <= req.key;
						rd_vld_q <= 1'b0;
						cnt_q    <= '0;
						if (POW2) begin
							addr_q  <= req.key[LW-1:0];
							state_q <= S_PROBE;
						end else begin
							mstep_q <= '0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (mstep_q == 2'd0) begin
						acc_q   <= {16'b0, prod};
						mstep_q <= 2'd1;
					end else if (mstep_q == 2'd1) begin
						acc_q   <= acc_q + {prod, 16'b0};
						mstep_q <= 2'd2;
					end else begin
						addr_q  <= rem_nxt;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					addr_q     <= addr_nxt;
					cmp_addr_q <= addr_q;
					rd_vld_q   <= 1'b1;
					if (rd_vld_q) begin
						if (hit) begin
							hit_q      <= 1'b1;
							hit_addr_q <= cmp_addr_q;
							state_q    <= S_WRITE;
						end else if (cnt_q == LAST) begin
							hit_q   <= 1'b0;
							state_q <= S_WRITE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_WRITE: begin
					if (wr_go) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
						if (hit_q) begin
							status_q <= ST_DONE;
							slot_q   <= SLOT_W'(hit_addr_q);
							live_q   <= live_nxt;
							occ_q    <= OCC_W'(live_nxt);
						end else begin
							status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
							slot_q   <= '0;
							occ_q    <= OCC_W'(live_q);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_vld_q;
	assign rsp.status    = status_q;
	assign rsp.slot      = slot_q;
	assign rsp.occupancy = occ_q;

	// The live count can never exceed the table size.
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_SLOTS))
		else $error("live count above table size");

	// A failed operation reports slot zero.
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_DONE |-> rsp.slot == '0)
		else $error("failed operation with non-zero slot");

	// A full table means every slot holds a live key.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(TABLE_SLOTS))
		else $error("table full reported below capacity");

	// A successful insert raises the live count by one.
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go && hit_q && op_q == OP_INSERT |=> live_q == $past(live_q) + 1'b1)
		else $error("insert did not raise live count");

	// The probe walk ends after the last slot has been compared.
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE && rd_vld_q && cnt_q == LAST |=> state_q == S_WRITE)
		else $error("probe walk ran past the table");

endmodule

`default_nettype wire
